// ----- design/fgcc_pkg.sv -----
// Shared types, widths and codes of the footprint grid collision checker.
`default_nettype none
package fgcc_pkg;

    localparam int ANGLE_W   = 16;
    localparam int CELL_W    = 10;
    localparam int HEAD_W    = 8;
    localparam int ENTRY_W   = 6;
    localparam int OFF_W     = 6;
    localparam int PACK_W    = 2 * OFF_W;
    localparam int COUNT_W   = 7;
    localparam int POSE_W    = 12;
    localparam int COORD_W   = 13;
    localparam int GRID_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [GRID_W-1:0] GRID_RESET = 11'd1024;

    localparam logic signed [7:0] VAL_OCCUPIED = 8'sd100;
    localparam logic signed [7:0] VAL_UNKNOWN  = -8'sd1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        FUNC_CELL   = 2'd0,
        FUNC_OFFSET = 2'd1,
        FUNC_LENGTH = 2'd2,
        FUNC_QUERY  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEN,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_func                     func;
        logic [CELL_W-1:0]         cell_x;
        logic [CELL_W-1:0]         cell_y;
        logic                      blocked;
        logic [HEAD_W-1:0]         heading;
        logic [ENTRY_W-1:0]        entry;
        logic signed [OFF_W-1:0]   offset_x;
        logic signed [OFF_W-1:0]   offset_y;
        logic [COUNT_W-1:0]        count;
        logic signed [POSE_W-1:0]  pose_x;
        logic signed [POSE_W-1:0]  pose_y;
    } t_cmd;

endpackage
`default_nettype wire

// ----- design/fgcc_ram.sv -----
// Generic single write port memory with a registered read port.
`default_nettype none
module fgcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- design/fgcc_front.sv -----
// Front end: accepts requests, checks ranges and turns each into a command.
`default_nettype none
module fgcc_front #(
    parameter int HEADINGS      = 72,
    parameter int MAX_FOOTPRINT = 64,
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024
) (
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_func,
    input  wire logic [fgcc_pkg::CELL_W-1:0]         i_cell_x,
    input  wire logic [fgcc_pkg::CELL_W-1:0]         i_cell_y,
    input  wire logic signed [7:0]                   i_cell_value,
    input  wire logic [6:0]                          i_heading_index,
    input  wire logic [fgcc_pkg::ENTRY_W-1:0]        i_entry_index,
    input  wire logic signed [fgcc_pkg::OFF_W-1:0]   i_offset_x,
    input  wire logic signed [fgcc_pkg::OFF_W-1:0]   i_offset_y,
    input  wire logic [fgcc_pkg::COUNT_W-1:0]        i_entry_count,
    input  wire logic signed [fgcc_pkg::POSE_W-1:0]  i_pose_x,
    input  wire logic signed [fgcc_pkg::POSE_W-1:0]  i_pose_y,
    input  wire logic [fgcc_pkg::ANGLE_W-1:0]        i_pose_angle,
    input  wire logic                                i_full,
    input  wire logic                                i_clearing,
    output logic                                     o_push,
    output fgcc_pkg::t_cmd                           o_cmd
);
    import fgcc_pkg::*;

    localparam int HIDX_W = $clog2(HEADINGS + 1);
    localparam int PROD_W = ANGLE_W + HIDX_W;

    logic [PROD_W-1:0] prod;
    logic [HIDX_W-1:0] query_heading;
    logic [HEAD_W-1:0] sel_heading;
    logic [COUNT_W-1:0] sat_count;
    logic              keep;
    t_func             func;

    always_comb begin
        func = t_func'(i_func);
        prod = PROD_W'(i_pose_angle) * PROD_W'(HEADINGS);
        query_heading = prod[PROD_W-1:ANGLE_W];
        if (int'(query_heading) >= HEADINGS) begin
            query_heading = HIDX_W'(HEADINGS - 1);
        end
        if (int'(i_entry_count) > MAX_FOOTPRINT) begin
            sat_count = COUNT_W'(MAX_FOOTPRINT);
        end else begin
            sat_count = i_entry_count;
        end
        sel_heading = HEAD_W'(i_heading_index);
        unique case (func)
            FUNC_CELL: begin
                keep = (int'(i_cell_x) < MAX_WIDTH) && (int'(i_cell_y) < MAX_HEIGHT);
            end
            FUNC_OFFSET: begin
                keep = (int'(i_heading_index) < HEADINGS) &&
                       (int'(i_entry_index) < MAX_FOOTPRINT);
            end
            FUNC_LENGTH: begin
                keep = int'(i_heading_index) < HEADINGS;
            end
            FUNC_QUERY: begin
                keep = 1'b1;
                sel_heading = HEAD_W'(query_heading);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_cmd.func     = func;
        o_cmd.cell_x   = i_cell_x;
        o_cmd.cell_y   = i_cell_y;
        o_cmd.blocked  = (i_cell_value == VAL_OCCUPIED) || (i_cell_value == VAL_UNKNOWN);
        o_cmd.heading  = sel_heading;
        o_cmd.entry    = i_entry_index;
        o_cmd.offset_x = i_offset_x;
        o_cmd.offset_y = i_offset_y;
        o_cmd.count    = sat_count;
        o_cmd.pose_x   = i_pose_x;
        o_cmd.pose_y   = i_pose_y;
    end

    assign o_in_stall = i_full || i_clearing;
    assign o_push     = i_in_valid && !o_in_stall && keep;

endmodule
`default_nettype wire

// ----- design/fgcc_queue.sv -----
// Short command queue between the front end and the back end.
`default_nettype none
module fgcc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  fgcc_pkg::t_cmd      i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output fgcc_pkg::t_cmd      o_head
);
    import fgcc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

endmodule
`default_nettype wire

// ----- design/fgcc_back.sv -----
// Back end: holds the grid and templates, runs writes and footprint walks.
`default_nettype none
module fgcc_back #(
    parameter int HEADINGS      = 72,
    parameter int MAX_FOOTPRINT = 64,
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [fgcc_pkg::GRID_W-1:0]   i_grid_width,
    input  wire logic [fgcc_pkg::GRID_W-1:0]   i_grid_height,
    input  wire logic                          i_empty,
    input  fgcc_pkg::t_cmd                     i_head,
    output logic                               o_pop,
    output logic                               o_clearing,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_is_free
);
    import fgcc_pkg::*;

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int GA_W  = $clog2(CELLS);
    localparam int SLOTS = HEADINGS * MAX_FOOTPRINT;
    localparam int OA_W  = $clog2(SLOTS);
    localparam int HD_W  = $clog2(HEADINGS);

    t_state                     r_state, n_state;
    logic [GA_W-1:0]            r_clr_addr, n_clr_addr;
    logic [HD_W-1:0]            r_heading, n_heading;
    logic signed [POSE_W-1:0]   r_pose_x, n_pose_x;
    logic signed [POSE_W-1:0]   r_pose_y, n_pose_y;
    logic [COUNT_W-1:0]         r_len, n_len;
    logic [COUNT_W-1:0]         r_issue, n_issue;
    logic                       r_s1, n_s1;
    logic                       r_s2, n_s2;
    logic                       r_s2_out, n_s2_out;
    logic                       r_fail, n_fail;
    logic [HEADINGS-1:0]        r_len_valid, n_len_valid;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_free, n_out_free;

    logic                       grid_we, grid_wdata, grid_re, grid_rdata;
    logic [GA_W-1:0]            grid_waddr, grid_raddr, cell_addr;
    logic                       off_we, off_re;
    logic [OA_W-1:0]            off_waddr, off_raddr;
    logic [PACK_W-1:0]          off_rdata;
    logic                       len_we, len_re;
    logic [COUNT_W-1:0]         len_rdata;
    logic [HD_W-1:0]            head_heading;
    logic                       issue, can_load;
    logic signed [OFF_W-1:0]    walk_ox, walk_oy;
    logic signed [COORD_W-1:0]  cx, cy;
    logic [COORD_W-1:0]         w_eff, h_eff;
    logic                       s1_out;

    always_comb begin
        head_heading = i_head.heading[HD_W-1:0];
        cell_addr = GA_W'(GA_W'(i_head.cell_y) * GA_W'(MAX_WIDTH) + GA_W'(i_head.cell_x));
        off_waddr = OA_W'(OA_W'(head_heading) * OA_W'(MAX_FOOTPRINT) + OA_W'(i_head.entry));
        off_raddr = OA_W'(OA_W'(r_heading) * OA_W'(MAX_FOOTPRINT) + OA_W'(r_issue));

        w_eff = (int'(i_grid_width) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH)
                                                 : COORD_W'(i_grid_width);
        h_eff = (int'(i_grid_height) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT)
                                                   : COORD_W'(i_grid_height);
        walk_ox = signed'(off_rdata[PACK_W-1:OFF_W]);
        walk_oy = signed'(off_rdata[OFF_W-1:0]);
        cx = COORD_W'(r_pose_x) + COORD_W'(walk_ox);
        cy = COORD_W'(r_pose_y) + COORD_W'(walk_oy);
        s1_out = cx[COORD_W-1] || cy[COORD_W-1] ||
                 ($unsigned(cx) >= w_eff) || ($unsigned(cy) >= h_eff);
        grid_raddr = GA_W'(GA_W'($unsigned(cy)) * GA_W'(MAX_WIDTH) + GA_W'($unsigned(cx)));
        grid_re = r_s1;

        issue    = (r_issue < r_len) && !r_fail;
        can_load = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_heading   = r_heading;
        n_pose_x    = r_pose_x;
        n_pose_y    = r_pose_y;
        n_len       = r_len;
        n_issue     = r_issue;
        n_s1        = 1'b0;
        n_s2        = 1'b0;
        n_s2_out    = s1_out;
        n_fail      = r_fail;
        n_len_valid = r_len_valid;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_free  = r_out_free;
        o_pop       = 1'b0;
        grid_we     = 1'b0;
        grid_waddr  = cell_addr;
        grid_wdata  = i_head.blocked;
        off_we      = 1'b0;
        off_re      = 1'b0;
        len_we      = 1'b0;
        len_re      = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = r_clr_addr;
                grid_wdata = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == GA_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_head.func)
                        FUNC_CELL: begin
                            grid_we = 1'b1;
                        end
                        FUNC_OFFSET: begin
                            off_we = 1'b1;
                        end
                        FUNC_LENGTH: begin
                            len_we = 1'b1;
                            n_len_valid[head_heading] = 1'b1;
                        end
                        FUNC_QUERY: begin
                            len_re    = 1'b1;
                            n_heading = head_heading;
                            n_pose_x  = i_head.pose_x;
                            n_pose_y  = i_head.pose_y;
                            n_state   = ST_LEN;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LEN: begin
                n_len   = r_len_valid[r_heading] ? len_rdata : '0;
                n_issue = '0;
                n_fail  = 1'b0;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                off_re = issue;
                n_s1   = issue;
                n_s2   = r_s1;
                if (issue) begin
                    n_issue = r_issue + 1'b1;
                end
                if (r_s2 && (r_s2_out || grid_rdata)) begin
                    n_fail = 1'b1;
                end
                if (!issue && !r_s1 && !r_s2) begin
                    if (can_load) begin
                        n_out_valid = 1'b1;
                        n_out_free  = !r_fail;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_free  = !r_fail;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_s1        <= 1'b0;
            r_s2        <= 1'b0;
            r_fail      <= 1'b0;
            r_len_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_s1        <= n_s1;
            r_s2        <= n_s2;
            r_fail      <= n_fail;
            r_len_valid <= n_len_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_heading  <= n_heading;
        r_pose_x   <= n_pose_x;
        r_pose_y   <= n_pose_y;
        r_len      <= n_len;
        r_issue    <= n_issue;
        r_s2_out   <= n_s2_out;
        r_out_free <= n_out_free;
    end

    fgcc_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (grid_waddr),
        .i_wdata (grid_wdata),
        .i_re    (grid_re),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    fgcc_ram #(
        .WIDTH (PACK_W),
        .DEPTH (SLOTS)
    ) u_offset_ram (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_waddr (off_waddr),
        .i_wdata ({i_head.offset_x, i_head.offset_y}),
        .i_re    (off_re),
        .i_raddr (off_raddr),
        .o_rdata (off_rdata)
    );

    fgcc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (HEADINGS)
    ) u_length_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (head_heading),
        .i_wdata (i_head.count),
        .i_re    (len_re),
        .i_raddr (head_heading),
        .o_rdata (len_rdata)
    );

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_is_free   = r_out_free;

endmodule
`default_nettype wire

// ----- design/footprint_grid_collision_check.sv -----
// Top level of the footprint collision checker on a one-bit occupancy grid.
//
// Requests load grid cells, template offsets and template lengths, or query a pose; only
// a query returns a result. A front end checks and classifies each request and places
// those in range in a short command queue; the back end runs one command at a time. A
// load is written in the back end as it is popped from the queue. A query takes the
// command, reads the template length of the selected heading, issues the template cells
// one per cycle, drains the offset memory read and the grid memory read of the two-stage
// pipeline, and loads the result. The walk stops issuing once a blocked or outside cell
// comes out of the pipeline, and a finished query waits while an earlier result is still
// stalled. After reset the grid memory is swept to blocked, one cell per cycle, over all
// MAX_WIDTH * MAX_HEIGHT cells (1048576 with the default sizes); requests are stalled
// during that sweep, while configuration writes are taken.
`default_nettype none
module footprint_grid_collision_check #(
    parameter int HEADINGS      = 72,
    parameter int MAX_FOOTPRINT = 64,
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int QUEUE_DEPTH   = 2
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [fgcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fgcc_pkg::GRID_W-1:0]         i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_func,
    input  wire logic [fgcc_pkg::CELL_W-1:0]         i_cell_x,
    input  wire logic [fgcc_pkg::CELL_W-1:0]         i_cell_y,
    input  wire logic signed [7:0]                   i_cell_value,
    input  wire logic [6:0]                          i_heading_index,
    input  wire logic [fgcc_pkg::ENTRY_W-1:0]        i_entry_index,
    input  wire logic signed [fgcc_pkg::OFF_W-1:0]   i_offset_x,
    input  wire logic signed [fgcc_pkg::OFF_W-1:0]   i_offset_y,
    input  wire logic [fgcc_pkg::COUNT_W-1:0]        i_entry_count,
    input  wire logic signed [fgcc_pkg::POSE_W-1:0]  i_pose_x,
    input  wire logic signed [fgcc_pkg::POSE_W-1:0]  i_pose_y,
    input  wire logic [fgcc_pkg::ANGLE_W-1:0]        i_pose_angle,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_is_free
);
    import fgcc_pkg::*;

    logic [GRID_W-1:0] r_grid_width;
    logic [GRID_W-1:0] r_grid_height;
    logic              push, pop, full, empty, clearing;
    t_cmd              cmd, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_RESET;
            r_grid_height <= GRID_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == REG_GRID_WIDTH) begin
                r_grid_width <= i_cfg_data;
            end
            if (i_cfg_index == REG_GRID_HEIGHT) begin
                r_grid_height <= i_cfg_data;
            end
        end
    end

    fgcc_front #(
        .HEADINGS      (HEADINGS),
        .MAX_FOOTPRINT (MAX_FOOTPRINT),
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT)
    ) u_front (
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_value    (i_cell_value),
        .i_heading_index (i_heading_index),
        .i_entry_index   (i_entry_index),
        .i_offset_x      (i_offset_x),
        .i_offset_y      (i_offset_y),
        .i_entry_count   (i_entry_count),
        .i_pose_x        (i_pose_x),
        .i_pose_y        (i_pose_y),
        .i_pose_angle    (i_pose_angle),
        .i_full          (full),
        .i_clearing      (clearing),
        .o_push          (push),
        .o_cmd           (cmd)
    );

    fgcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    fgcc_back #(
        .HEADINGS      (HEADINGS),
        .MAX_FOOTPRINT (MAX_FOOTPRINT),
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_is_free     (o_is_free)
    );

endmodule
`default_nettype wire

// ----- tb/footprint_grid_collision_check_tb.sv -----
// Self-checking testbench for the footprint grid collision checker.
`default_nettype none
module footprint_grid_collision_check_tb;
    import fgcc_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int HEADINGS       = 72;
    localparam int MAX_FP         = 64;
    localparam int MAX_W          = 1024;
    localparam int MAX_H          = 1024;
    localparam int MAP_CELLS      = MAX_W * MAX_H;
    localparam int RAND_ITEMS     = 1500;
    localparam int NUM_PHASES     = 8;
    localparam int SETTLE_CYCLES  = 200;
    localparam int TIMEOUT_CYCLES = 6_000_000;
    localparam int PREDICT        = -1;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef struct packed {
        t_func                    func;
        logic [CELL_W-1:0]        cell_x;
        logic [CELL_W-1:0]        cell_y;
        logic signed [7:0]        cell_value;
        logic [6:0]               heading_index;
        logic [ENTRY_W-1:0]       entry_index;
        logic signed [OFF_W-1:0]  offset_x;
        logic signed [OFF_W-1:0]  offset_y;
        logic [COUNT_W-1:0]       entry_count;
        logic signed [POSE_W-1:0] pose_x;
        logic signed [POSE_W-1:0] pose_y;
        logic [ANGLE_W-1:0]       pose_angle;
        logic                     has_exp;
        logic                     exp_free;
    } t_grid_req;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [GRID_W-1:0]          i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [1:0]                 i_func;
    logic [CELL_W-1:0]          i_cell_x;
    logic [CELL_W-1:0]          i_cell_y;
    logic signed [7:0]          i_cell_value;
    logic [6:0]                 i_heading_index;
    logic [ENTRY_W-1:0]         i_entry_index;
    logic signed [OFF_W-1:0]    i_offset_x;
    logic signed [OFF_W-1:0]    i_offset_y;
    logic [COUNT_W-1:0]         i_entry_count;
    logic signed [POSE_W-1:0]   i_pose_x;
    logic signed [POSE_W-1:0]   i_pose_y;
    logic [ANGLE_W-1:0]         i_pose_angle;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_is_free;

    bit                      cell_blocked [MAP_CELLS];
    logic signed [OFF_W-1:0] fp_dx [HEADINGS][MAX_FP];
    logic signed [OFF_W-1:0] fp_dy [HEADINGS][MAX_FP];
    bit                      fp_written [HEADINGS][MAX_FP];
    int                      fp_len [HEADINGS];
    logic [GRID_W-1:0]       grid_cols;
    logic [GRID_W-1:0]       grid_rows;

    bit expected_free_q [$];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int applied_items = 0;
    int results_checked = 0;
    int free_results = 0;
    int mismatches = 0;

    int phase_cols [NUM_PHASES] = '{1024, 2047, 1, 48, 0, 700, 1025, 16};
    int phase_rows [NUM_PHASES] = '{1024, 1500, 1, 32, 512, 0, 1, 1024};

    footprint_grid_collision_check dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_cell_value   (i_cell_value),
        .i_heading_index(i_heading_index),
        .i_entry_index  (i_entry_index),
        .i_offset_x     (i_offset_x),
        .i_offset_y     (i_offset_y),
        .i_entry_count  (i_entry_count),
        .i_pose_x       (i_pose_x),
        .i_pose_y       (i_pose_y),
        .i_pose_angle   (i_pose_angle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_free      (o_is_free)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timed out at %0t with %0d results outstanding.", $time,
                 expected_free_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        bit want;
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_free_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got is_free %0b",
                         $time, o_is_free);
                mismatches++;
            end else begin
                want = expected_free_q.pop_front();
                results_checked++;
                if (o_is_free === 1'b1)
                    free_results++;
                if (o_is_free !== want) begin
                    $display("%0t: is_free mismatch, expected %0b, got %0b",
                             $time, want, o_is_free);
                    mismatches++;
                end
            end
        end
    end

    function automatic bit footprint_is_free(int px, int py, int ang);
        int hdg;
        int cols;
        int rows;
        int cx;
        int cy;
        bit ok;
        hdg = (ang * HEADINGS) >> 16;
        if (hdg >= HEADINGS)
            hdg = HEADINGS - 1;
        cols = (int'(grid_cols) > MAX_W) ? MAX_W : int'(grid_cols);
        rows = (int'(grid_rows) > MAX_H) ? MAX_H : int'(grid_rows);
        ok = 1'b1;
        for (int i = 0; i < fp_len[hdg]; i++) begin
            cx = px + int'(fp_dx[hdg][i]);
            cy = py + int'(fp_dy[hdg][i]);
            if (cx < 0 || cy < 0 || cx >= cols || cy >= rows ||
                cell_blocked[cy * MAX_W + cx]) begin
                ok = 1'b0;
                break;
            end
        end
        return ok;
    endfunction

    function automatic int template_prefix(int hdg);
        int p;
        p = 0;
        while (p < MAX_FP && fp_written[hdg][p])
            p++;
        return p;
    endfunction

    function automatic void predict_request(t_grid_req r);
        int hdg;
        hdg = int'(r.heading_index);
        case (r.func)
            FUNC_CELL: begin
                cell_blocked[int'(r.cell_y) * MAX_W + int'(r.cell_x)] =
                    (r.cell_value == VAL_OCCUPIED || r.cell_value == VAL_UNKNOWN);
                applied_items++;
            end
            FUNC_OFFSET: begin
                if (hdg < HEADINGS) begin
                    fp_dx[hdg][r.entry_index] = r.offset_x;
                    fp_dy[hdg][r.entry_index] = r.offset_y;
                    fp_written[hdg][r.entry_index] = 1'b1;
                    applied_items++;
                end
            end
            FUNC_LENGTH: begin
                if (hdg < HEADINGS) begin
                    fp_len[hdg] = (int'(r.entry_count) > MAX_FP) ? MAX_FP : int'(r.entry_count);
                    applied_items++;
                end
            end
            default: begin
                if (r.has_exp)
                    expected_free_q.push_back(r.exp_free);
                else
                    expected_free_q.push_back(footprint_is_free(int'(r.pose_x),
                                              int'(r.pose_y), int'(r.pose_angle)));
                applied_items++;
            end
        endcase
    endfunction

    function automatic t_grid_req random_req();
        t_grid_req r;
        r.func          = t_func'($urandom_range(3));
        r.cell_x        = CELL_W'($urandom);
        r.cell_y        = CELL_W'($urandom);
        r.cell_value    = 8'($urandom);
        r.heading_index = 7'($urandom);
        r.entry_index   = ENTRY_W'($urandom);
        r.offset_x      = OFF_W'($urandom);
        r.offset_y      = OFF_W'($urandom);
        r.entry_count   = COUNT_W'($urandom);
        r.pose_x        = POSE_W'($urandom);
        r.pose_y        = POSE_W'($urandom);
        r.pose_angle    = ANGLE_W'($urandom);
        r.has_exp       = 1'b0;
        r.exp_free      = 1'b0;
        return r;
    endfunction

    function automatic t_grid_req cell_row(int x, int y, int v);
        t_grid_req r;
        r = random_req();
        r.func       = FUNC_CELL;
        r.cell_x     = CELL_W'(x);
        r.cell_y     = CELL_W'(y);
        r.cell_value = 8'(v);
        return r;
    endfunction

    function automatic t_grid_req offset_row(int hdg, int e, int dx, int dy);
        t_grid_req r;
        r = random_req();
        r.func          = FUNC_OFFSET;
        r.heading_index = 7'(hdg);
        r.entry_index   = ENTRY_W'(e);
        r.offset_x      = OFF_W'(dx);
        r.offset_y      = OFF_W'(dy);
        return r;
    endfunction

    function automatic t_grid_req length_row(int hdg, int n);
        t_grid_req r;
        r = random_req();
        r.func          = FUNC_LENGTH;
        r.heading_index = 7'(hdg);
        r.entry_count   = COUNT_W'(n);
        return r;
    endfunction

    function automatic t_grid_req query_row(int px, int py, int ang, int expv);
        t_grid_req r;
        r = random_req();
        r.func       = FUNC_QUERY;
        r.pose_x     = POSE_W'(px);
        r.pose_y     = POSE_W'(py);
        r.pose_angle = ANGLE_W'(ang);
        r.has_exp    = (expv != PREDICT);
        r.exp_free   = (expv == 1);
        return r;
    endfunction

    function automatic int blocked_value();
        return $urandom_range(1) ? int'(VAL_OCCUPIED) : int'(VAL_UNKNOWN);
    endfunction

    function automatic int free_value();
        int v;
        v = int'($urandom_range(255)) - 128;
        if (v == int'(VAL_OCCUPIED) || v == int'(VAL_UNKNOWN))
            v = 0;
        return v;
    endfunction

    task automatic push_request(input t_grid_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= r.func;
        i_cell_x        <= r.cell_x;
        i_cell_y        <= r.cell_y;
        i_cell_value    <= r.cell_value;
        i_heading_index <= r.heading_index;
        i_entry_index   <= r.entry_index;
        i_offset_x      <= r.offset_x;
        i_offset_y      <= r.offset_y;
        i_entry_count   <= r.entry_count;
        i_pose_x        <= r.pose_x;
        i_pose_y        <= r.pose_y;
        i_pose_angle    <= r.pose_angle;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_request(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GRID_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_GRID_WIDTH)
            grid_cols = val;
        else if (idx == REG_GRID_HEIGHT)
            grid_rows = val;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_free_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A template for one heading, some of the grid cells under it around a pose, its
    // length, and then a few queries of that heading near the pose.
    task automatic run_pose_sequence();
        int hdg;
        int n;
        bit wide;
        int cols;
        int rows;
        int px;
        int py;
        int cx;
        int cy;
        int ang_lo;
        int ang_hi;
        int dx [MAX_FP];
        int dy [MAX_FP];
        hdg  = $urandom_range(HEADINGS - 1);
        n    = ($urandom_range(39) == 0) ? MAX_FP : $urandom_range(1, 8);
        wide = ($urandom_range(3) == 0);
        for (int e = 0; e < n; e++) begin
            if (wide) begin
                dx[e] = int'($urandom_range(63)) - 32;
                dy[e] = int'($urandom_range(63)) - 32;
            end else begin
                dx[e] = int'($urandom_range(6)) - 3;
                dy[e] = int'($urandom_range(6)) - 3;
            end
            push_request(offset_row(hdg, e, dx[e], dy[e]));
        end
        cols = (int'(grid_cols) > MAX_W) ? MAX_W : int'(grid_cols);
        rows = (int'(grid_rows) > MAX_H) ? MAX_H : int'(grid_rows);
        px = (cols > 0) ? $urandom_range(cols - 1) : $urandom_range(63);
        py = (rows > 0) ? $urandom_range(rows - 1) : $urandom_range(63);
        for (int e = 0; e < n; e++) begin
            cx = px + dx[e];
            cy = py + dy[e];
            if (cx >= 0 && cx < MAX_W && cy >= 0 && cy < MAX_H && $urandom_range(3) != 0) begin
                push_request(cell_row(cx, cy,
                             ($urandom_range(9) == 0) ? blocked_value() : free_value()));
            end
        end
        push_request(length_row(hdg, (n == MAX_FP) ? $urandom_range(MAX_FP, 127) : n));
        ang_lo = (hdg * 65536 + HEADINGS - 1) / HEADINGS;
        ang_hi = ((hdg + 1) * 65536 + HEADINGS - 1) / HEADINGS - 1;
        repeat ($urandom_range(1, 4)) begin
            push_request(query_row(px + int'($urandom_range(2)) - 1,
                                   py + int'($urandom_range(2)) - 1,
                                   $urandom_range(ang_lo, ang_hi), PREDICT));
        end
    endtask

    // Any request at all, except that a template length never reaches past
    // the entries written so far.
    task automatic run_noise_item();
        t_grid_req r;
        int p;
        r = random_req();
        if (r.func == FUNC_CELL && $urandom_range(3) == 0)
            r.cell_value = 8'(blocked_value());
        if (r.func == FUNC_LENGTH && int'(r.heading_index) < HEADINGS) begin
            p = template_prefix(int'(r.heading_index));
            r.entry_count = COUNT_W'((p == MAX_FP) ? $urandom_range(127) : $urandom_range(p));
        end
        push_request(r);
    endtask

    initial begin
        t_grid_req dir_rows [$];
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = REG_GRID_WIDTH;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_func          = FUNC_CELL;
        i_cell_x        = '0;
        i_cell_y        = '0;
        i_cell_value    = '0;
        i_heading_index = '0;
        i_entry_index   = '0;
        i_offset_x      = '0;
        i_offset_y      = '0;
        i_entry_count   = '0;
        i_pose_x        = '0;
        i_pose_y        = '0;
        i_pose_angle    = '0;
        for (int i = 0; i < MAP_CELLS; i++)
            cell_blocked[i] = 1'b1;
        for (int h = 0; h < HEADINGS; h++) begin
            fp_len[h] = 0;
            for (int e = 0; e < MAX_FP; e++)
                fp_written[h][e] = 1'b0;
        end
        grid_cols = GRID_RESET;
        grid_rows = GRID_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(REG_GRID_WIDTH, GRID_RESET);
        write_reg(REG_GRID_HEIGHT, GRID_RESET);

        dir_rows.push_back(query_row(2047, -2048, 0, 1));
        dir_rows.push_back(query_row(-2048, 2047, 65535, 1));
        dir_rows.push_back(cell_row(0, 0, 0));
        dir_rows.push_back(cell_row(1, 0, -128));
        dir_rows.push_back(cell_row(2, 0, 100));
        dir_rows.push_back(cell_row(1023, 1023, 127));
        dir_rows.push_back(cell_row(1022, 1023, -1));
        dir_rows.push_back(cell_row(0, 1, 99));
        dir_rows.push_back(offset_row(0, 0, 0, 0));
        dir_rows.push_back(offset_row(0, 1, 1, 0));
        dir_rows.push_back(offset_row(71, 0, -32, 31));
        dir_rows.push_back(offset_row(71, 1, 31, -32));
        dir_rows.push_back(offset_row(127, 63, 31, 31));
        dir_rows.push_back(length_row(0, 2));
        dir_rows.push_back(length_row(127, 127));
        dir_rows.push_back(query_row(0, 0, 0, 1));
        dir_rows.push_back(query_row(1, 0, 0, 0));
        dir_rows.push_back(query_row(-1, 0, 0, 0));
        dir_rows.push_back(query_row(1023, 0, 910, 0));
        dir_rows.push_back(length_row(71, 2));
        dir_rows.push_back(query_row(1055, 992, 65535, PREDICT));
        dir_rows.push_back(length_row(71, 1));
        dir_rows.push_back(query_row(1055, 992, 65535, PREDICT));
        dir_rows.push_back(query_row(1054, 992, 64800, PREDICT));
        foreach (dir_rows[i])
            push_request(dir_rows[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            write_reg((p % 2 == 0) ? REG_UNUSED_2 : REG_UNUSED_3,
                      GRID_W'($urandom_range(2047)));
            write_reg(REG_GRID_WIDTH, GRID_W'(phase_cols[p]));
            write_reg(REG_GRID_HEIGHT, GRID_W'(phase_rows[p]));
            while (applied_items < 24 + (p + 1) * RAND_ITEMS / NUM_PHASES) begin
                if ($urandom_range(3) == 0)
                    run_noise_item();
                else
                    run_pose_sequence();
            end
            drain();
        end

        $display("Applied %0d requests over %0d grid size settings and four idling modes.",
                 applied_items, NUM_PHASES + 1);
        $display("Checked %0d query results, %0d of them free; %0d mismatches.",
                 results_checked, free_results, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
